/* src/pfm_pkg.sv */
// Package for the flood-map histogrammer: command and status codes,
// register indexes and fixed field widths. No dependencies.
package pfm_pkg;

  localparam int SIG_W = 16;
  localparam int BIN_W = 10;
  localparam int ENERGY_W = 18;
  localparam int OUT_W = 32;

  typedef enum logic [1:0] {
    CMD_EVENT = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_ALT   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_BINNED  = 3'd0,
    ST_ADDRESS = 3'd1,
    ST_FLAGS   = 3'd2,
    ST_LOW     = 3'd3,
    ST_HIGH    = 3'd4,
    ST_OFF_MAP = 3'd5,
    ST_READ    = 3'd6,
    ST_CLEARED = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    REG_CHANNEL_SELECT = 3'd0,
    REG_MATCH_ALL      = 3'd1,
    REG_FLAG_MASK      = 3'd2,
    REG_LOW_ENABLE     = 3'd3,
    REG_HIGH_ENABLE    = 3'd4,
    REG_FLOOR          = 3'd5,
    REG_CEILING        = 3'd6,
    REG_SIZE_CODE      = 3'd7
  } reg_idx_t;

endpackage

/* src/pet_flood_map_histogrammer.sv */
// Flood-map histogrammer top level: filters, Anger-logic divider,
// histogram memory and counters. Depends on pfm_pkg.
//
// Usage:
//  - Input channel in_valid/in_stall carries one command item: event, read
//    bin or clear. Result channel out_valid/out_stall returns one item each.
//  - Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the eight
//    registers; cfg_ready is always high. Write only while idle.
//  - An event that survives the filters runs two restoring divisions of
//    NUM_W (28) steps each on a shared divider (one quotient bit per cycle),
//    then a memory read, a modify and a write back (no memory steps when
//    the bin falls off the map). One item is in work at a time; the next
//    one is taken once the result register is loaded.
//  - The histogram memory has one row per entry and one read/write port.
//    After reset and after a clear command, a clearing pass writes zero to
//    every entry, one per cycle; during the pass no item is accepted
//    (config writes still are).
//  - Reset loads register defaults, zeros all counters and starts a pass.
//  - While out_stall is high the result holds; a new item may still be
//    accepted and worked on up to the point where its result is ready.
module pet_flood_map_histogrammer #(
  parameter int MAP_SIDE_MAX = 1024,
  parameter int COUNT_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [7:0]                    in_source_address,
  input  logic [7:0]                    in_event_flag_bits,
  input  logic [pfm_pkg::SIG_W-1:0]     in_plus_x_signal,
  input  logic [pfm_pkg::SIG_W-1:0]     in_minus_x_signal,
  input  logic [pfm_pkg::SIG_W-1:0]     in_plus_y_signal,
  input  logic [pfm_pkg::SIG_W-1:0]     in_minus_y_signal,
  input  logic [pfm_pkg::BIN_W-1:0]     in_read_bin_x,
  input  logic [pfm_pkg::BIN_W-1:0]     in_read_bin_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [pfm_pkg::BIN_W-1:0]     out_bin_x,
  output logic [pfm_pkg::BIN_W-1:0]     out_bin_y,
  output logic [pfm_pkg::OUT_W-1:0]     out_bin_count,
  output logic [pfm_pkg::OUT_W-1:0]     out_peak_count,
  output logic [pfm_pkg::OUT_W-1:0]     out_events_seen,
  output logic [pfm_pkg::OUT_W-1:0]     out_events_binned,
  output logic [pfm_pkg::OUT_W-1:0]     out_address_rejects,
  output logic [pfm_pkg::OUT_W-1:0]     out_flag_rejects,
  output logic [pfm_pkg::OUT_W-1:0]     out_low_energy_rejects,
  output logic [pfm_pkg::OUT_W-1:0]     out_high_energy_rejects,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [17:0]                   cfg_data
);

  localparam int AW     = $clog2(MAP_SIDE_MAX);
  localparam int DEPTH  = MAP_SIDE_MAX * MAP_SIDE_MAX;
  localparam int ADDR_W = 2 * AW;
  localparam int SW     = pfm_pkg::SIG_W;
  // numerator 2*side*p + sum < 2^(SW+12); denominator 2*sum < 2^(SW+2)
  localparam int NUM_W  = SW + 12;
  localparam int DEN_W  = SW + 2;
  localparam int Q_W    = 12;
  localparam int REM_W  = DEN_W + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FILTER, S_DIV_X, S_DIV_Y, S_RD, S_RMW, S_WB, S_READ_RD, S_READ_DO,
    S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [7:0]  chan_sel_r, flag_mask_r;
  logic        match_all_r, low_en_r, high_en_r;
  logic [17:0] floor_r, ceil_r;
  logic [1:0]  size_code_r;

  // item registers
  logic [1:0]  cmd_r;
  logic [7:0]  src_r, flags_r;
  logic [SW-1:0] xp_r, xn_r, yp_r, yn_r;
  logic [pfm_pkg::BIN_W-1:0] rx_r, ry_r;

  // counters
  logic [COUNT_BITS-1:0] peak_r, seen_r, binned_r, addr_rej_r, flag_rej_r;
  logic [COUNT_BITS-1:0] low_rej_r, high_rej_r;

  // divider
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [REM_W-1:0] rem_r;
  logic [Q_W-1:0]   quo_r;
  logic [4:0]       step_r;
  logic [Q_W-1:0]   qx_r;

  // memory
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [ADDR_W-1:0]     clr_addr_r;
  logic [ADDR_W-1:0]     addr_r;
  logic                  rd_en, wr_en;
  logic [ADDR_W-1:0]     mem_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] cell_r;
  logic                  clr_reply_r;

  // work registers for the result being built
  logic                  out_valid_r;
  logic [2:0]            o_status_r;
  logic [pfm_pkg::BIN_W-1:0] o_bx_r, o_by_r;
  logic [COUNT_BITS-1:0] o_cnt_r;

  // result register, held while the receiver stalls
  logic [2:0]            res_status_r;
  logic [pfm_pkg::BIN_W-1:0] res_bx_r, res_by_r;
  logic [COUNT_BITS-1:0] res_cnt_r, res_peak_r, res_seen_r, res_binned_r;
  logic [COUNT_BITS-1:0] res_addr_rej_r, res_flag_rej_r, res_low_rej_r, res_high_rej_r;

  logic [11:0] side;
  logic [SW+1:0] energy;
  logic [SW:0]   sum_x, sum_y;
  logic [REM_W-1:0] rem_sh, rem_sub;
  logic [Q_W-1:0]   quo_nxt;
  logic          in_acc, out_acc, pass_en;

  always_comb begin
    unique case (size_code_r)
      2'd0:    side = 12'd256;
      2'd1:    side = 12'd512;
      default: side = 12'd1024;
    endcase
    if (side > 12'(MAP_SIDE_MAX)) side = 12'(MAP_SIDE_MAX);
  end

  assign energy = (SW+2)'(xp_r) + (SW+2)'(xn_r) + (SW+2)'(yp_r) + (SW+2)'(yn_r);
  assign sum_x  = (SW+1)'(xp_r) + (SW+1)'(xn_r);
  assign sum_y  = (SW+1)'(yp_r) + (SW+1)'(yn_r);

  // one restoring step: shift in next numerator bit, try subtract
  assign rem_sh  = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
  assign rem_sub = rem_sh - REM_W'(den_r);
  assign quo_nxt = {quo_r[Q_W-2:0], ~rem_sub[REM_W-1]};

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign pass_en  = (state_r == S_OUT) && (!out_valid_r || out_acc);
  assign cfg_ready = 1'b1;

  // memory port control
  always_comb begin
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    mem_addr = addr_r;
    wr_data  = cell_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_en    = 1'b1;
        mem_addr = clr_addr_r;
        wr_data  = '0;
      end
      S_RD, S_READ_RD: rd_en = 1'b1;
      S_WB:    wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[mem_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[mem_addr];
  end

  function automatic logic [NUM_W-1:0] anger_num(input logic [SW-1:0] p,
                                                  input logic [SW:0] s,
                                                  input logic [11:0] sd);
    logic [NUM_W-1:0] prod;
    prod = NUM_W'(sd) * NUM_W'(p);
    return (prod << 1) + NUM_W'(s);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      chan_sel_r  <= '0;
      match_all_r <= 1'b1;
      flag_mask_r <= 8'hFE;
      low_en_r    <= 1'b0;
      high_en_r   <= 1'b0;
      floor_r     <= '0;
      ceil_r      <= 18'(4 * 'hFFFF);
      size_code_r <= 2'd1;
      peak_r <= '0; seen_r <= '0; binned_r <= '0; addr_rej_r <= '0;
      flag_rej_r <= '0; low_rej_r <= '0; high_rej_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (pfm_pkg::reg_idx_t'(cfg_index))
          pfm_pkg::REG_CHANNEL_SELECT: chan_sel_r  <= cfg_data[7:0];
          pfm_pkg::REG_MATCH_ALL:      match_all_r <= cfg_data[0];
          pfm_pkg::REG_FLAG_MASK:      flag_mask_r <= cfg_data[7:0];
          pfm_pkg::REG_LOW_ENABLE:     low_en_r    <= cfg_data[0];
          pfm_pkg::REG_HIGH_ENABLE:    high_en_r   <= cfg_data[0];
          pfm_pkg::REG_FLOOR:          floor_r     <= cfg_data;
          pfm_pkg::REG_CEILING:        ceil_r      <= cfg_data;
          pfm_pkg::REG_SIZE_CODE:      size_code_r <= cfg_data[1:0];
          default: ;
        endcase
      end

      if (pass_en) out_valid_r <= 1'b1;
      else if (out_acc) out_valid_r <= 1'b0;

      // load the result register from the work registers and counters
      if (pass_en) begin
        res_status_r   <= o_status_r;
        res_bx_r       <= o_bx_r;
        res_by_r       <= o_by_r;
        res_cnt_r      <= o_cnt_r;
        res_peak_r     <= peak_r;
        res_seen_r     <= seen_r;
        res_binned_r   <= binned_r;
        res_addr_rej_r <= addr_rej_r;
        res_flag_rej_r <= flag_rej_r;
        res_low_rej_r  <= low_rej_r;
        res_high_rej_r <= high_rej_r;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == ADDR_W'(DEPTH - 1)) state_r <= clr_reply_r ? S_OUT : S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_command; src_r <= in_source_address;
            flags_r <= in_event_flag_bits;
            xp_r <= in_plus_x_signal; xn_r <= in_minus_x_signal;
            yp_r <= in_plus_y_signal; yn_r <= in_minus_y_signal;
            rx_r <= in_read_bin_x; ry_r <= in_read_bin_y;
            state_r <= S_FILTER;
          end
        end
        S_FILTER: begin
          unique case (pfm_pkg::cmd_t'(cmd_r))
            pfm_pkg::CMD_CLEAR: begin
              o_bx_r <= '0; o_by_r <= '0; o_cnt_r <= '0;
              o_status_r <= pfm_pkg::ST_CLEARED;
              peak_r <= '0; seen_r <= '0; binned_r <= '0; addr_rej_r <= '0;
              flag_rej_r <= '0; low_rej_r <= '0; high_rej_r <= '0;
              clr_addr_r <= '0;
              clr_reply_r <= 1'b1;
              state_r <= S_CLEAR;
            end
            pfm_pkg::CMD_READ, pfm_pkg::CMD_ALT: begin
              o_status_r <= pfm_pkg::ST_READ;
              o_bx_r <= rx_r; o_by_r <= ry_r;
              addr_r <= {rx_r[AW-1:0], ry_r[AW-1:0]};
              state_r <= S_READ_RD;
            end
            default: begin
              o_bx_r <= '0; o_by_r <= '0; o_cnt_r <= '0;
              seen_r <= seen_r + 1'b1;
              state_r <= S_OUT;
              if (!match_all_r && src_r != chan_sel_r) begin
                addr_rej_r <= addr_rej_r + 1'b1;
                o_status_r <= pfm_pkg::ST_ADDRESS;
              end else if ((flag_mask_r & flags_r) != 8'd0) begin
                flag_rej_r <= flag_rej_r + 1'b1;
                o_status_r <= pfm_pkg::ST_FLAGS;
              end else if (low_en_r && energy < 18'(floor_r)) begin
                low_rej_r <= low_rej_r + 1'b1;
                o_status_r <= pfm_pkg::ST_LOW;
              end else if (high_en_r && energy > 18'(ceil_r)) begin
                high_rej_r <= high_rej_r + 1'b1;
                o_status_r <= pfm_pkg::ST_HIGH;
              end else if (sum_x == '0 || sum_y == '0) begin
                o_status_r <= pfm_pkg::ST_OFF_MAP;
              end else begin
                num_r  <= anger_num(xp_r, sum_x, side);
                den_r  <= {sum_x, 1'b0};
                rem_r  <= '0;
                quo_r  <= '0;
                step_r <= '0;
                state_r <= S_DIV_X;
              end
            end
          endcase
        end
        S_DIV_X, S_DIV_Y: begin
          if (step_r != 5'(NUM_W - 1)) begin
            num_r  <= num_r << 1;
            rem_r  <= rem_sub[REM_W-1] ? rem_sh : rem_sub;
            quo_r  <= quo_nxt;
            step_r <= step_r + 1'b1;
          end else if (state_r == S_DIV_X) begin
            qx_r   <= quo_nxt;
            num_r  <= anger_num(yp_r, sum_y, side);
            den_r  <= {sum_y, 1'b0};
            rem_r  <= '0;
            quo_r  <= '0;
            step_r <= '0;
            state_r <= S_DIV_Y;
          end else if (qx_r >= side || quo_nxt >= side) begin
            o_status_r <= pfm_pkg::ST_OFF_MAP;
            state_r <= S_OUT;
          end else begin
            o_bx_r <= qx_r[pfm_pkg::BIN_W-1:0];
            o_by_r <= quo_nxt[pfm_pkg::BIN_W-1:0];
            addr_r <= {qx_r[AW-1:0], quo_nxt[AW-1:0]};
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_RMW;
        S_RMW: begin
          cell_r <= (rd_data_r != CNT_MAX) ? rd_data_r + 1'b1 : rd_data_r;
          state_r <= S_WB;
        end
        S_WB: begin
          if (cell_r > peak_r) peak_r <= cell_r;
          binned_r   <= binned_r + 1'b1;
          o_cnt_r    <= cell_r;
          o_status_r <= pfm_pkg::ST_BINNED;
          state_r    <= S_OUT;
        end
        S_READ_RD: state_r <= S_READ_DO;
        S_READ_DO: begin
          o_cnt_r <= (32'(rx_r) < 32'(MAP_SIDE_MAX) && 32'(ry_r) < 32'(MAP_SIDE_MAX))
                     ? rd_data_r : '0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (pass_en) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = res_status_r;
  assign out_bin_x               = res_bx_r;
  assign out_bin_y               = res_by_r;
  assign out_bin_count           = pfm_pkg::OUT_W'(res_cnt_r);
  assign out_peak_count          = pfm_pkg::OUT_W'(res_peak_r);
  assign out_events_seen         = pfm_pkg::OUT_W'(res_seen_r);
  assign out_events_binned       = pfm_pkg::OUT_W'(res_binned_r);
  assign out_address_rejects     = pfm_pkg::OUT_W'(res_addr_rej_r);
  assign out_flag_rejects        = pfm_pkg::OUT_W'(res_flag_rej_r);
  assign out_low_energy_rejects  = pfm_pkg::OUT_W'(res_low_rej_r);
  assign out_high_energy_rejects = pfm_pkg::OUT_W'(res_high_rej_r);

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_acc) else $error("item accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(res_status_r)
      && $stable(res_cnt_r) && $stable(res_seen_r))
    else $error("result dropped under stall");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en)) else $error("memory port used twice");
  a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WB |=> peak_r >= $past(cell_r)) else $error("peak below bin");

endmodule

/* dv/tb_pet_flood_map_histogrammer.sv */
// Self-checking testbench for pet_flood_map_histogrammer: predicts every
// result item from its own histogram/counter image. Depends on pfm_pkg.
`timescale 1ns / 1ps

module tb_pet_flood_map_histogrammer;

  localparam int SIDE_MAX = 1024;
  localparam longint IDLE_LIMIT = 3_500_000;

  typedef struct packed {
    pfm_pkg::cmd_t cmd;
    logic [7:0]  src;
    logic [7:0]  flags;
    logic [15:0] xp, xn, yp, yn;
    logic [9:0]  rx, ry;
  } command_t;

  typedef struct packed {
    pfm_pkg::status_t st;
    logic [9:0]  bx, by;
    logic [31:0] cnt, peak, seen, binned, addr_rej, flag_rej, low_rej, high_rej;
  } flood_result_t;

  class flood_map_tracker;
    int unsigned hist[int unsigned];
    logic [31:0] peak, seen, binned, addr_rej, flag_rej, low_rej, high_rej;
    logic [7:0]  chan_sel, flag_mask;
    logic        match_all, low_en, high_en;
    logic [17:0] floor_e, ceil_e;
    logic [1:0]  size_code;
    logic [9:0]  last_x, last_y;
    flood_result_t pending_results[$];
    int errors;

    function new();
      clear_counts();
      chan_sel = 0; match_all = 1; flag_mask = 8'hFE; low_en = 0; high_en = 0;
      floor_e = 0; ceil_e = 18'd262140; size_code = 1;
      last_x = 0; last_y = 0; errors = 0;
    endfunction

    function void clear_counts();
      hist.delete();
      peak = 0; seen = 0; binned = 0;
      addr_rej = 0; flag_rej = 0; low_rej = 0; high_rej = 0;
    endfunction

    function void set_reg(pfm_pkg::reg_idx_t idx, logic [17:0] v);
      case (idx)
        pfm_pkg::REG_CHANNEL_SELECT: chan_sel = v[7:0];
        pfm_pkg::REG_MATCH_ALL:      match_all = v[0];
        pfm_pkg::REG_FLAG_MASK:      flag_mask = v[7:0];
        pfm_pkg::REG_LOW_ENABLE:     low_en = v[0];
        pfm_pkg::REG_HIGH_ENABLE:    high_en = v[0];
        pfm_pkg::REG_FLOOR:          floor_e = v;
        pfm_pkg::REG_CEILING:        ceil_e = v;
        default:                     size_code = v[1:0];
      endcase
    endfunction

    // Returns 0 on zero sum; the bin may equal the side.
    function bit anger_bin(logic [15:0] p, logic [15:0] n, longint side,
                           output longint b);
      longint s;
      s = longint'(p) + longint'(n);
      b = 0;
      if (s == 0) return 0;
      b = (2 * side * longint'(p) + s) / (2 * s);
      return 1;
    endfunction

    function void note_command(command_t c);
      flood_result_t r;
      longint side, x, y, energy;
      int unsigned key;
      bit okx, oky;
      r = '0;
      if (c.cmd == pfm_pkg::CMD_CLEAR) begin
        clear_counts();
        r.st = pfm_pkg::ST_CLEARED;
      end else if (c.cmd != pfm_pkg::CMD_EVENT) begin
        r.st = pfm_pkg::ST_READ; r.bx = c.rx; r.by = c.ry;
        key = 32'({c.rx, c.ry});
        r.cnt = hist.exists(key) ? hist[key] : 32'd0;
      end else begin
        side = (size_code == 3) ? 1024 : (256 << size_code);
        if (side > SIDE_MAX) side = SIDE_MAX;
        energy = longint'(c.xp) + c.xn + c.yp + c.yn;
        seen++;
        okx = anger_bin(c.xp, c.xn, side, x);
        oky = anger_bin(c.yp, c.yn, side, y);
        if (!match_all && c.src != chan_sel) begin
          addr_rej++; r.st = pfm_pkg::ST_ADDRESS;
        end else if ((flag_mask & c.flags) != 0) begin
          flag_rej++; r.st = pfm_pkg::ST_FLAGS;
        end else if (low_en && energy < floor_e) begin
          low_rej++; r.st = pfm_pkg::ST_LOW;
        end else if (high_en && energy > ceil_e) begin
          high_rej++; r.st = pfm_pkg::ST_HIGH;
        end else if (!okx || !oky || x >= side || y >= side) begin
          r.st = pfm_pkg::ST_OFF_MAP;
        end else begin
          key = 32'(x * SIDE_MAX + y);
          if (!hist.exists(key)) hist[key] = 0;
          if (hist[key] != 32'hFFFF_FFFF) hist[key]++;
          if (hist[key] > peak) peak = hist[key];
          binned++;
          r.st = pfm_pkg::ST_BINNED; r.bx = 10'(x); r.by = 10'(y); r.cnt = hist[key];
          last_x = 10'(x); last_y = 10'(y);
        end
      end
      r.peak = peak; r.seen = seen; r.binned = binned; r.addr_rej = addr_rej;
      r.flag_rej = flag_rej; r.low_rej = low_rej; r.high_rej = high_rej;
      pending_results.push_back(r);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        errors++;
        if (errors < 60)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(flood_result_t a);
      flood_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, status %0d", $time, a.st);
        return;
      end
      e = pending_results.pop_front();
      cmp("status", e.st, a.st);
      cmp("bin_x", e.bx, a.bx);
      cmp("bin_y", e.by, a.by);
      cmp("bin_count", e.cnt, a.cnt);
      cmp("peak_count", e.peak, a.peak);
      cmp("events_seen", e.seen, a.seen);
      cmp("events_binned", e.binned, a.binned);
      cmp("address_rejects", e.addr_rej, a.addr_rej);
      cmp("flag_rejects", e.flag_rej, a.flag_rej);
      cmp("low_energy_rejects", e.low_rej, a.low_rej);
      cmp("high_energy_rejects", e.high_rej, a.high_rej);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_command = '0;
  logic [7:0] in_source_address = '0, in_event_flag_bits = '0;
  logic [15:0] in_plus_x_signal = '0, in_minus_x_signal = '0;
  logic [15:0] in_plus_y_signal = '0, in_minus_y_signal = '0;
  logic [9:0] in_read_bin_x = '0, in_read_bin_y = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] out_status;
  logic [9:0] out_bin_x, out_bin_y;
  logic [31:0] out_bin_count, out_peak_count, out_events_seen, out_events_binned;
  logic [31:0] out_address_rejects, out_flag_rejects;
  logic [31:0] out_low_energy_rejects, out_high_energy_rejects;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;

  flood_map_tracker tracker = new();
  bit in_fire, out_fire;
  longint idle_cycles;
  int burst_left;
  logic [15:0] hot_p[8], hot_n[8];

  always #5 clk = ~clk;

  pet_flood_map_histogrammer u_top (.*);

  // Handshakes are evaluated mid-cycle, where all inputs and outputs are settled.
  always @(negedge clk) begin
    flood_result_t r;
    in_fire = in_valid && !in_stall;
    out_fire = out_valid && !out_stall;
    if (rst_n && out_fire) begin
      r.st = pfm_pkg::status_t'(out_status); r.bx = out_bin_x; r.by = out_bin_y;
      r.cnt = out_bin_count; r.peak = out_peak_count; r.seen = out_events_seen;
      r.binned = out_events_binned; r.addr_rej = out_address_rejects;
      r.flag_rej = out_flag_rejects; r.low_rej = out_low_energy_rejects;
      r.high_rej = out_high_energy_rejects;
      tracker.check_result(r);
    end
  end

  // Receiver stall pattern: quiet stretches, light stalls and long holds.
  always @(posedge clk) begin
    int mode;
    mode = int'(($time / 40000) % 4);
    case (mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (($time / 10) % 23) < 15;
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** pet_flood_map_histogrammer: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(pfm_pkg::reg_idx_t idx, logic [17:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    tracker.set_reg(idx, v);
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic write_all(logic [7:0] ch, logic ma, logic [7:0] mask, logic le,
                           logic he, logic [17:0] fl, logic [17:0] ce,
                           logic [1:0] sz);
    write_reg(pfm_pkg::REG_CHANNEL_SELECT, 18'(ch));
    write_reg(pfm_pkg::REG_MATCH_ALL, 18'(ma));
    write_reg(pfm_pkg::REG_FLAG_MASK, 18'(mask));
    write_reg(pfm_pkg::REG_LOW_ENABLE, 18'(le));
    write_reg(pfm_pkg::REG_HIGH_ENABLE, 18'(he));
    write_reg(pfm_pkg::REG_FLOOR, fl);
    write_reg(pfm_pkg::REG_CEILING, ce);
    write_reg(pfm_pkg::REG_SIZE_CODE, 18'(sz));
    cfg_valid <= 1'b0;
  endtask

  // Hold valid across back-to-back items; drop it only for a gap.
  task automatic send_command(command_t c);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= c.cmd;
    in_source_address <= c.src;
    in_event_flag_bits <= c.flags;
    in_plus_x_signal <= c.xp;
    in_minus_x_signal <= c.xn;
    in_plus_y_signal <= c.yp;
    in_minus_y_signal <= c.yn;
    in_read_bin_x <= c.rx;
    in_read_bin_y <= c.ry;
    do @(negedge clk); while (!(in_valid && !in_stall));
    tracker.note_command(c);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic command_t make_event(logic [7:0] flags, logic [15:0] xp,
                                          logic [15:0] xn, logic [15:0] yp,
                                          logic [15:0] yn);
    command_t c;
    c = '{cmd: pfm_pkg::CMD_EVENT, src: 8'($urandom), flags: flags, xp: xp, xn: xn,
          yp: yp, yn: yn, rx: 10'($urandom), ry: 10'($urandom)};
    return c;
  endfunction

  function automatic command_t random_command();
    command_t c;
    int k, pick;
    c = make_event(8'h00, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      if ($urandom_range(0, 9) < 8) c.src = tracker.chan_sel;
      if ($urandom_range(0, 9) < 2) c.flags = 8'($urandom);
      else if ($urandom_range(0, 1) == 0) c.flags = ~tracker.flag_mask & 8'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // Repeat a few positions so bins build up counts.
          k = $urandom_range(0, 7);
          c.xp = hot_p[k]; c.xn = hot_n[k];
          k = $urandom_range(0, 7);
          c.yp = hot_p[k]; c.yn = hot_n[k];
        end
        4: c.xn = 0;
        5: begin c.yp = 0; c.yn = ($urandom_range(0, 1) == 0) ? 16'd0 : c.yn; end
        6: begin
          c.xp = 16'($urandom_range(0, 255));
          c.yn = 16'($urandom_range(0, 255));
        end
        default: ;
      endcase
    end else if (pick < 92) begin
      c.cmd = pfm_pkg::CMD_READ;
      if ($urandom_range(0, 1) == 0) begin
        c.rx = tracker.last_x; c.ry = tracker.last_y;
      end
    end else if (pick < 95) begin
      c.cmd = pfm_pkg::CMD_ALT;
    end
    return c;
  endfunction

  initial begin
    command_t c;
    burst_left = 0;
    idle_cycles = 0;
    foreach (hot_p[i]) begin
      hot_p[i] = 16'($urandom_range(1, 65535));
      hot_n[i] = 16'($urandom_range(1, 65535));
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset settings.
    send_command(make_event(8'h00, 16'd100, 16'd100, 16'd100, 16'd100));
    send_command(make_event(8'h01, 16'd100, 16'd100, 16'd100, 16'd100));
    send_command(make_event(8'h80, 16'd5, 16'd5, 16'd5, 16'd5));
    send_command(make_event(8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_command(make_event(8'h00, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF));
    send_command(make_event(8'h00, 16'hFFFF, 16'd0, 16'd3, 16'd3));
    send_command(make_event(8'h00, 16'd0, 16'd0, 16'd3, 16'd3));
    send_command(make_event(8'h00, 16'd3, 16'd3, 16'd0, 16'd0));
    send_command(make_event(8'h00, 16'd1, 16'hFFFF, 16'hFFFE, 16'd1));
    send_command(make_event(8'hFF, 16'd1, 16'd1, 16'd1, 16'd1));
    c = make_event(8'h00, 16'd0, 16'd0, 16'd0, 16'd0);
    c.cmd = pfm_pkg::CMD_READ; c.rx = tracker.last_x; c.ry = tracker.last_y;
    send_command(c);
    c.rx = 10'h3FF; c.ry = 10'h3FF;
    send_command(c);
    c.rx = 10'd900; c.ry = 10'd3;
    send_command(c);
    c.cmd = pfm_pkg::CMD_ALT; c.rx = tracker.last_x; c.ry = tracker.last_y;
    send_command(c);
    c.cmd = pfm_pkg::CMD_CLEAR;
    send_command(c);
    c.cmd = pfm_pkg::CMD_READ;
    send_command(c);
    send_command(make_event(8'h00, 16'd7, 16'd9, 16'd11, 16'd13));
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_all(8'h5A, 1'b0, 8'h00, 1'b1, 1'b1, 18'd1000, 18'd200000, 2'd0);
        1: write_all(8'hFF, 1'b1, 8'hFF, 1'b0, 1'b1, 18'd0, 18'd0, 2'd2);
        2: write_all(8'h00, 1'b0, 8'h01, 1'b1, 1'b0, 18'd262140, 18'd262140, 2'd3);
        3: write_all(8'hA5, 1'b1, 8'h00, 1'b1, 1'b1, 18'd0, 18'h3FFFF, 2'd2);
        default: write_all(8'h33, 1'b0, 8'h80, 1'b1, 1'b1, 18'h3FFFF, 18'd150000, 2'd0);
      endcase
      for (int n = 0; n < 230; n++) begin
        c = random_command();
        if (phase == 3 && n == 115) c.cmd = pfm_pkg::CMD_CLEAR;
        send_command(c);
      end
      drain();
    end

    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("** pet_flood_map_histogrammer: PASSED **");
    end else begin
      $display("** pet_flood_map_histogrammer: FAILED **");
    end
    $finish;
  end

endmodule
